/* rtl/bti_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the bilinear table interpolator.
// Used by bti_front, bti_back, bti_interp and the top level; depends on nothing.
package bti_pkg;

	// Width of the signed intermediate values of the interpolation passes.
	localparam int WIDE_W = 104;
	// Width of a coordinate difference or an axis span.
	localparam int DIFF_W = 33;
	// Width of the pass step counter.
	localparam int CNT_W = 7;

	typedef enum logic [1:0] {
		OP_WR_X   = 2'd0,
		OP_WR_Y   = 2'd1,
		OP_WR_TAB = 2'd2,
		OP_LOOKUP = 2'd3
	} op_t;

	typedef struct packed {
		op_t                kind;
		logic [2:0]         row;
		logic [2:0]         col;
		logic signed [31:0] value;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} cmd_t;

	// Operands of one interpolation pass.
	typedef struct packed {
		logic signed [WIDE_W-1:0] q1;
		logic signed [WIDE_W-1:0] q2;
		logic signed [31:0]       c;
		logic signed [31:0]       c1;
		logic signed [31:0]       c2;
	} ipu_req_t;

	typedef enum logic [1:0] {
		IP_IDLE,
		IP_MUL,
		IP_DIV,
		IP_FIN
	} ip_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SCAN_RD,
		B_SCAN_CMP,
		B_FETCH,
		B_PASS,
		B_WAIT,
		B_DONE
	} back_state_t;

endpackage

/* rtl/bti_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input words, classifies them and queues them for the back end.
// Depends on bti_pkg.
module bti_front #(
	parameter int POINTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bti_pkg::op_t        in_op,
	input  logic [2:0]          in_row,
	input  logic [2:0]          in_col,
	input  logic signed [31:0]  in_value,
	input  logic signed [31:0]  in_x,
	input  logic signed [31:0]  in_y,
	output logic                head_valid,
	output bti_pkg::cmd_t       head,
	input  logic                pop
);

	localparam int DEPTH = 4;

	bti_pkg::cmd_t fifo_q [DEPTH];
	logic [1:0]    wr_ptr_q;
	logic [1:0]    rd_ptr_q;
	logic [2:0]    count_q;
	logic          accept;
	logic          in_range;
	logic          push;
	bti_pkg::cmd_t cmd;

	assign in_ready   = (count_q != 3'(DEPTH));
	assign accept     = in_valid & in_ready;
	assign head_valid = (count_q != 3'd0);
	assign head       = fifo_q[rd_ptr_q];

	// Writes to positions beyond the table are dropped here.
	always_comb begin
		unique case (in_op)
			bti_pkg::OP_WR_X, bti_pkg::OP_WR_Y: in_range = ({4'd0, in_row} < 7'(POINTS));
			bti_pkg::OP_WR_TAB: in_range = ({4'd0, in_row} < 7'(POINTS))
				&& ({4'd0, in_col} < 7'(POINTS));
			default: in_range = 1'b1;
		endcase
	end

	assign push = accept & in_range;

	always_comb begin
		cmd.kind  = in_op;
		cmd.row   = in_row;
		cmd.col   = in_col;
		cmd.value = in_value;
		cmd.x     = in_x;
		cmd.y     = in_y;
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {2'd0, push} - {2'd0, pop};
		end
	end

endmodule

/* rtl/bti_interp.sv */
`timescale 1ns / 1ps
// One linear interpolation pass: shift-add multiply, then restoring floor division.
// Depends on bti_pkg.
module bti_interp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  bti_pkg::ipu_req_t                 req,
	output logic                              done,
	output logic signed [bti_pkg::WIDE_W-1:0] res
);

	localparam int W = bti_pkg::WIDE_W;
	localparam int D = bti_pkg::DIFF_W;

	bti_pkg::ip_state_t         state_q;
	logic [bti_pkg::CNT_W-1:0]  cnt_q;
	logic signed [W-1:0]        q1_q;
	logic [W-1:0]               a_q;
	logic [W-1:0]               acc_q;
	logic [D-1:0]               b_q;
	logic [D-1:0]               d_q;
	logic [D-1:0]               rem_q;
	logic                       neg_q;
	logic                       done_q;
	logic signed [W-1:0]        res_q;

	logic signed [W-1:0]        dq;
	logic signed [D-1:0]        dc;
	logic signed [D-1:0]        sp;
	logic [D:0]                 trial;
	logic                       fits;
	logic [W-1:0]               addend;

	assign done = done_q;
	assign res  = res_q;

	// Differences of the operands.
	always_comb begin
		dq    = req.q2 - req.q1;
		dc    = {req.c[31], req.c} - {req.c1[31], req.c1};
		sp    = {req.c2[31], req.c2} - {req.c1[31], req.c1};
		trial = {rem_q, acc_q[W-1]};
		fits  = (trial >= {1'b0, d_q});
		// A negative quotient rounds toward minus infinity.
		addend = neg_q ? (~acc_q + W'(rem_q == '0)) : acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bti_pkg::IP_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				bti_pkg::IP_IDLE: begin
					if (start) begin
						if (sp == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= bti_pkg::IP_MUL;
						end
					end
				end
				bti_pkg::IP_MUL: begin
					if (cnt_q == bti_pkg::CNT_W'(D - 1)) begin
						state_q <= bti_pkg::IP_DIV;
					end
				end
				bti_pkg::IP_DIV: begin
					if (cnt_q == bti_pkg::CNT_W'(W - 1)) begin
						state_q <= bti_pkg::IP_FIN;
					end
				end
				bti_pkg::IP_FIN: begin
					done_q  <= 1'b1;
					state_q <= bti_pkg::IP_IDLE;
				end
				default: state_q <= bti_pkg::IP_IDLE;
			endcase
		end
	end

	// Datapath: magnitudes are multiplied and divided, the sign is applied at the end.
	always_ff @(posedge clk) begin
		unique case (state_q)
			bti_pkg::IP_IDLE: begin
				q1_q  <= req.q1;
				a_q   <= dq[W-1] ? W'(-dq) : W'(dq);
				b_q   <= dc[D-1] ? D'(-dc) : D'(dc);
				d_q   <= sp[D-1] ? D'(-sp) : D'(sp);
				neg_q <= dq[W-1] ^ dc[D-1] ^ sp[D-1];
				acc_q <= '0;
				rem_q <= '0;
				cnt_q <= '0;
				res_q <= req.q1;
			end
			bti_pkg::IP_MUL: begin
				if (b_q[0]) begin
					acc_q <= acc_q + a_q;
				end
				a_q <= {a_q[W-2:0], 1'b0};
				b_q <= {1'b0, b_q[D-1:1]};
				cnt_q <= (cnt_q == bti_pkg::CNT_W'(D - 1)) ? '0 : cnt_q + 1'b1;
			end
			bti_pkg::IP_DIV: begin
				rem_q <= fits ? D'(trial - {1'b0, d_q}) : D'(trial);
				acc_q <= {acc_q[W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
			end
			bti_pkg::IP_FIN: begin
				res_q <= q1_q + $signed(addend);
			end
			default: ;
		endcase
	end

endmodule

/* rtl/bti_back.sv */
`timescale 1ns / 1ps
// Back end: breakpoint and table memories, segment search, corner fetch, passes, output.
// Depends on bti_pkg and bti_interp.
module bti_back #(
	parameter int POINTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  bti_pkg::cmd_t       head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  out_result,
	output logic                out_saturated
);

	localparam int W  = bti_pkg::WIDE_W;
	localparam int IW = (POINTS > 1) ? $clog2(POINTS) : 1;
	localparam int TW = $clog2(POINTS * POINTS);

	bti_pkg::back_state_t state_q, state_d;

	logic signed [31:0] xbp [POINTS];
	logic signed [31:0] ybp [POINTS];
	logic signed [31:0] tab [POINTS * POINTS];
	logic signed [31:0] xbp_rd_q, ybp_rd_q, tab_rd_q;
	logic [IW-1:0]      xbp_ra, ybp_ra;
	logic [TW-1:0]      tab_ra;

	logic signed [31:0] x_q, y_q;
	logic               axis_q;
	logic [IW-1:0]      i_q;
	logic [IW-1:0]      xh_q, yh_q;
	logic [3:0]         k_q;
	logic [1:0]         pass_q;
	logic signed [31:0] xc1_q, xc2_q, yc1_q, yc2_q;
	logic signed [31:0] q11_q, q12_q, q21_q, q22_q;
	logic signed [W-1:0] r1_q, r2_q, p_q;

	logic               out_v_q;
	logic signed [31:0] out_res_q;
	logic               out_sat_q;

	logic               scan_hit;
	logic signed [31:0] scan_d;
	logic               ip_start;
	bti_pkg::ipu_req_t  ip_req;
	logic               ip_done;
	logic signed [W-1:0] ip_res;
	logic               out_free;
	logic               p_fits;
	logic [TW-1:0]      row_lo, row_hi, col_lo, col_hi;
	logic [TW-1:0]      wr_tab_a;

	assign out_valid     = out_v_q;
	assign out_result    = out_res_q;
	assign out_saturated = out_sat_q;
	assign out_free      = !out_v_q || out_ready;

	// Segment search compare.
	assign scan_d   = axis_q ? ybp_rd_q : xbp_rd_q;
	assign scan_hit = (scan_d >= (axis_q ? y_q : x_q)) || (i_q == IW'(POINTS - 1));

	// Corner addresses in the table.
	always_comb begin
		row_lo   = TW'(yh_q - 1'b1) * TW'(POINTS);
		row_hi   = TW'(yh_q) * TW'(POINTS);
		col_lo   = TW'(xh_q - 1'b1);
		col_hi   = TW'(xh_q);
		wr_tab_a = TW'({4'd0, head.row}) * TW'(POINTS) + TW'({4'd0, head.col});
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bti_pkg::B_IDLE: begin
				if (head_valid && head.kind == bti_pkg::OP_LOOKUP) begin
					state_d = bti_pkg::B_SCAN_RD;
				end
			end
			bti_pkg::B_SCAN_RD: state_d = bti_pkg::B_SCAN_CMP;
			bti_pkg::B_SCAN_CMP: begin
				if (scan_hit && axis_q) begin
					state_d = bti_pkg::B_FETCH;
				end else begin
					state_d = bti_pkg::B_SCAN_RD;
				end
			end
			bti_pkg::B_FETCH: begin
				if (k_q == 4'd8) begin
					state_d = bti_pkg::B_PASS;
				end
			end
			bti_pkg::B_PASS: state_d = bti_pkg::B_WAIT;
			bti_pkg::B_WAIT: begin
				if (ip_done) begin
					state_d = (pass_q == 2'd2) ? bti_pkg::B_DONE : bti_pkg::B_PASS;
				end
			end
			bti_pkg::B_DONE: begin
				if (out_free) begin
					state_d = bti_pkg::B_IDLE;
				end
			end
			default: state_d = bti_pkg::B_IDLE;
		endcase
	end

	// Outputs of the sequencer: queue pop, memory read addresses, pass start.
	always_comb begin
		pop      = (state_q == bti_pkg::B_IDLE) && head_valid;
		ip_start = (state_q == bti_pkg::B_PASS);
		xbp_ra   = i_q;
		ybp_ra   = i_q;
		tab_ra   = row_lo + col_lo;
		if (state_q == bti_pkg::B_FETCH) begin
			xbp_ra = (k_q == 4'd0) ? xh_q - 1'b1 : xh_q;
			ybp_ra = (k_q == 4'd2) ? yh_q - 1'b1 : yh_q;
			unique case (k_q)
				4'd5:    tab_ra = row_lo + col_hi;
				4'd6:    tab_ra = row_hi + col_lo;
				4'd7:    tab_ra = row_hi + col_hi;
				default: tab_ra = row_lo + col_lo;
			endcase
		end
	end

	// Pass operands.
	always_comb begin
		unique case (pass_q)
			2'd0: begin
				ip_req.q1 = W'(q11_q);
				ip_req.q2 = W'(q12_q);
				ip_req.c  = x_q;
				ip_req.c1 = xc1_q;
				ip_req.c2 = xc2_q;
			end
			2'd1: begin
				ip_req.q1 = W'(q21_q);
				ip_req.q2 = W'(q22_q);
				ip_req.c  = x_q;
				ip_req.c1 = xc1_q;
				ip_req.c2 = xc2_q;
			end
			default: begin
				ip_req.q1 = r1_q;
				ip_req.q2 = r2_q;
				ip_req.c  = y_q;
				ip_req.c1 = yc1_q;
				ip_req.c2 = yc2_q;
			end
		endcase
	end

	// Memories: written from load words, read with a registered port.
	always_ff @(posedge clk) begin
		if (pop && head.kind == bti_pkg::OP_WR_X) begin
			xbp[IW'(head.row)] <= head.value;
		end
		if (pop && head.kind == bti_pkg::OP_WR_Y) begin
			ybp[IW'(head.row)] <= head.value;
		end
		if (pop && head.kind == bti_pkg::OP_WR_TAB) begin
			tab[wr_tab_a] <= head.value;
		end
		xbp_rd_q <= xbp[xbp_ra];
		ybp_rd_q <= ybp[ybp_ra];
		tab_rd_q <= tab[tab_ra];
	end

	// Lookup datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			bti_pkg::B_IDLE: begin
				x_q    <= head.x;
				y_q    <= head.y;
				axis_q <= 1'b0;
				i_q    <= '0;
				k_q    <= 4'd0;
				pass_q <= 2'd0;
			end
			bti_pkg::B_SCAN_CMP: begin
				if (scan_hit) begin
					if (axis_q) begin
						yh_q <= (i_q == '0) ? IW'(1) : i_q;
					end else begin
						xh_q <= (i_q == '0) ? IW'(1) : i_q;
					end
					axis_q <= 1'b1;
					i_q    <= '0;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			bti_pkg::B_FETCH: begin
				k_q <= k_q + 4'd1;
				unique case (k_q)
					4'd1: xc1_q <= xbp_rd_q;
					4'd2: xc2_q <= xbp_rd_q;
					4'd3: yc1_q <= ybp_rd_q;
					4'd4: yc2_q <= ybp_rd_q;
					4'd5: q11_q <= tab_rd_q;
					4'd6: q12_q <= tab_rd_q;
					4'd7: q21_q <= tab_rd_q;
					4'd8: q22_q <= tab_rd_q;
					default: ;
				endcase
			end
			bti_pkg::B_WAIT: begin
				if (ip_done) begin
					pass_q <= pass_q + 2'd1;
					unique case (pass_q)
						2'd0:    r1_q <= ip_res;
						2'd1:    r2_q <= ip_res;
						default: p_q  <= ip_res;
					endcase
				end
			end
			default: ;
		endcase
	end

	// Saturation of the final value to 32 bits.
	assign p_fits = (&p_q[W-1:31]) || !(|p_q[W-1:31]);

	// Output register.
	always_ff @(posedge clk) begin
		if (state_q == bti_pkg::B_DONE && out_free) begin
			out_res_q <= p_fits ? p_q[31:0] : (p_q[W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);
			out_sat_q <= !p_fits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bti_pkg::B_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bti_pkg::B_DONE && out_free) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	bti_interp u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ip_start),
		.req    (ip_req),
		.done   (ip_done),
		.res    (ip_res)
	);

endmodule

/* rtl/bilinear_table_interpolator_core.sv */
`timescale 1ns / 1ps
// Top level of the bilinear table interpolator: front end, command queue and back end.
// Depends on bti_pkg, bti_front, bti_back.
//
//  Port group   Direction  Word contents
//  s_*          in         load word (x, y breakpoint or table entry) or lookup point
//  m_*          out        interpolated value and saturation flag, one per lookup
//
// A load word is written to its store as it leaves the queue. A lookup leaves the queue,
// searches the x and y breakpoints, fetches its corners, runs three passes in the shared
// multiply-divide unit and loads the output register; a pass ends early when its span
// is zero.
// The four-word queue takes words until full while a lookup runs or a result waits.
// Reset empties the queue and the output register; the stores hold no valid data.
module bilinear_table_interpolator_core #(
	parameter int POINTS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// row_index[2:0], column_index[5:3], write_value[37:6], x_coord[69:38],
	// y_coord[101:70], zero[103:102]
	input  logic [103:0] s_tdata,
	// operation[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// result[31:0]
	output logic [31:0]  m_tdata,
	// saturated[0]
	output logic [0:0]   m_tuser
);

	logic               head_valid;
	bti_pkg::cmd_t      head;
	logic               pop;
	logic signed [31:0] res;
	logic               sat;

	bti_front #(.POINTS(POINTS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (bti_pkg::op_t'(s_tuser)),
		.in_row     (s_tdata[2:0]),
		.in_col     (s_tdata[5:3]),
		.in_value   (s_tdata[37:6]),
		.in_x       (s_tdata[69:38]),
		.in_y       (s_tdata[101:70]),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	bti_back #(.POINTS(POINTS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_result    (res),
		.out_saturated (sat)
	);

	assign m_tdata = res;
	assign m_tuser = sat;

endmodule

/* test/bilinear_table_interpolator_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bilinear_table_interpolator_core: loads axes and tables,
// sends lookups and compares each result word with a bilinear predictor held here.
// Depends on bti_pkg and the core RTL.
module bilinear_table_interpolator_core_tb;

	typedef struct {
		bti_pkg::op_t       kind;
		logic [2:0]         row;
		logic [2:0]         col;
		logic signed [31:0] value;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               chk;
		logic signed [31:0] exp_val;
		logic               exp_sat;
	} stim_row_t;

	typedef struct {
		logic signed [31:0] val;
		logic               sat;
	} lookup_res_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [31:0]  m_tdata;
	logic [0:0]   m_tuser;

	logic signed [31:0] x_axis [8];
	logic signed [31:0] y_axis [8];
	logic signed [31:0] grid [64];
	lookup_res_t        pending_results [$];
	stim_row_t          directed [$];
	int                 n_errors;
	bit                 stim_done;

	bilinear_table_interpolator_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#200ms;
		$display("DONE: errors detected");
		$finish;
	end

	// Floor division of a signed wide value.
	function automatic logic signed [127:0] div_floor(logic signed [127:0] n,
			logic signed [127:0] d);
		logic signed [127:0] q;
		logic signed [127:0] r;
		q = n / d;
		r = n - q * d;
		if (r != 0 && ((r < 0) != (d < 0)))
			q = q - 1;
		return q;
	endfunction

	// One linear pass along a segment.
	function automatic logic signed [127:0] lerp_segment(logic signed [127:0] q1,
			logic signed [127:0] q2, logic signed [127:0] c,
			logic signed [127:0] c1, logic signed [127:0] c2);
		if (c2 == c1)
			return q1;
		return q1 + div_floor((q2 - q1) * (c - c1), c2 - c1);
	endfunction

	// Segment search with clamping to the inner intervals.
	function automatic int find_segment(bit use_y, logic signed [31:0] c);
		int i;
		i = 0;
		while (i < 8 && (use_y ? y_axis[i] : x_axis[i]) < c)
			i++;
		if (i < 1)
			i = 1;
		if (i > 7)
			i = 7;
		return i;
	endfunction

	function automatic lookup_res_t interpolate(logic signed [31:0] x, logic signed [31:0] y);
		int xh;
		int yh;
		logic signed [127:0] r1;
		logic signed [127:0] r2;
		logic signed [127:0] p;
		lookup_res_t res;
		xh = find_segment(1'b0, x);
		yh = find_segment(1'b1, y);
		r1 = lerp_segment(grid[(yh-1)*8+xh-1], grid[(yh-1)*8+xh], x,
			x_axis[xh-1], x_axis[xh]);
		r2 = lerp_segment(grid[yh*8+xh-1], grid[yh*8+xh], x, x_axis[xh-1], x_axis[xh]);
		p = lerp_segment(r1, r2, y, y_axis[yh-1], y_axis[yh]);
		res.sat = 1'b0;
		res.val = p[31:0];
		if (p > 128'sd2147483647) begin
			res.sat = 1'b1;
			res.val = 32'h7fffffff;
		end else if (p < -128'sd2147483648) begin
			res.sat = 1'b1;
			res.val = 32'h80000000;
		end
		return res;
	endfunction

	// Updates the predictor and records the expected result of a lookup.
	function automatic void predict_word(stim_row_t w);
		lookup_res_t r;
		case (w.kind)
			bti_pkg::OP_WR_X: x_axis[w.row] = w.value;
			bti_pkg::OP_WR_Y: y_axis[w.row] = w.value;
			bti_pkg::OP_WR_TAB: grid[w.row*8+w.col] = w.value;
			default: begin
				r = interpolate(w.x, w.y);
				if (w.chk && (r.val !== w.exp_val || r.sat !== w.exp_sat)) begin
					$display("%0t predictor disagrees with table: expected %h/%b got %h/%b",
						$time, w.exp_val, w.exp_sat, r.val, r.sat);
					n_errors++;
				end
				pending_results.push_back(r);
			end
		endcase
	endfunction

	function automatic stim_row_t mk(bti_pkg::op_t k, int r, int c, logic signed [31:0] v,
			logic signed [31:0] x, logic signed [31:0] y);
		stim_row_t s;
		s.kind = k; s.row = 3'(r); s.col = 3'(c); s.value = v; s.x = x; s.y = y;
		s.chk = 1'b0; s.exp_val = '0; s.exp_sat = 1'b0;
		return s;
	endfunction

	function automatic stim_row_t mk_chk(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] ev, logic es);
		stim_row_t s;
		s = mk(bti_pkg::OP_LOOKUP, $urandom, $urandom, $urandom, x, y);
		s.chk = 1'b1; s.exp_val = ev; s.exp_sat = es;
		return s;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Sends one word, with a random gap before it.
	task automatic send_word(stim_row_t w);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= w.kind;
		s_tdata  <= {2'b00, w.y, w.x, w.value, w.col, w.row};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_word(w);
		@(negedge clk);
	endtask

	// Writes a full set of axes and table: increasing axes, random grid.
	task automatic load_tables(int mode);
		int i;
		int b;
		int stepx;
		for (b = 0; b < 2; b++) begin
			stepx = $urandom_range(1, mode == 0 ? 2000 : 500000);
			for (i = 0; i < 8; i++)
				send_word(mk(b ? bti_pkg::OP_WR_Y : bti_pkg::OP_WR_X, i, 0,
					$signed(-4 * stepx + i * stepx + $urandom_range(0, stepx - 1)
						* (i == 0 ? 0 : 0)), 0, 0));
		end
		for (i = 0; i < 64; i++)
			send_word(mk(bti_pkg::OP_WR_TAB, i / 8, i % 8,
				mode == 2 ? ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000)
				: (mode == 1 ? $urandom : $signed($urandom_range(0, 200000)) - 100000),
				0, 0));
	endtask

	function automatic logic signed [31:0] rand_coord();
		int p;
		p = $urandom_range(0, 9);
		if (p == 0) return $urandom;
		if (p == 1) return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
		return $signed($urandom_range(0, 4000000)) - 2000000;
	endfunction

	// Stimulus: directed table, then loads and random lookups.
	initial begin
		int i;
		int k;
		int phase;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = bti_pkg::OP_WR_X;
		n_errors = 0;
		stim_done = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Unit axes 0..7 and a flat table of 1.0: every lookup inside gives 1.0.
		for (i = 0; i < 8; i++) begin
			directed.push_back(mk(bti_pkg::OP_WR_X, i, 0, i << 16, 0, 0));
			directed.push_back(mk(bti_pkg::OP_WR_Y, i, 0, i << 16, 0, 0));
		end
		for (i = 0; i < 64; i++)
			directed.push_back(mk(bti_pkg::OP_WR_TAB, i / 8, i % 8, 32'h00010000, 0, 0));
		directed.push_back(mk_chk(32'h00030000, 32'h00028000, 32'h00010000, 1'b0));
		directed.push_back(mk_chk(32'h7fffffff, 32'h80000000, 32'h00010000, 1'b0));
		directed.push_back(mk_chk(32'h80000000, 32'h7fffffff, 32'h00010000, 1'b0));
		// A steep corner extrapolated far out saturates both ways.
		directed.push_back(mk(bti_pkg::OP_WR_TAB, 7, 7, 32'h7fffffff, 0, 0));
		directed.push_back(mk_chk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1));
		directed.push_back(mk(bti_pkg::OP_WR_TAB, 7, 7, 32'h80000000, 0, 0));
		directed.push_back(mk_chk(32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b1));
		// Zero span: repeated breakpoint returns the lower corner.
		directed.push_back(mk(bti_pkg::OP_WR_X, 1, 0, 32'h00000000, 0, 0));
		directed.push_back(mk(bti_pkg::OP_WR_TAB, 0, 0, 32'h00050000, 0, 0));
		directed.push_back(mk_chk(32'h00000000, 32'h00000000, 32'h00050000, 1'b0));
		// Non-increasing axis, negative span.
		directed.push_back(mk(bti_pkg::OP_WR_X, 1, 0, 32'hfffe0000, 0, 0));
		directed.push_back(mk(bti_pkg::OP_LOOKUP, 0, 0, 0, 32'hffff0000, 32'h00008000));
		directed.push_back(mk(bti_pkg::OP_LOOKUP, 7, 7, 32'hffffffff, 32'h00048000,
			32'hfff00000));
		foreach (directed[j])
			send_word(directed[j]);

		// Random phases: small values, full range, and saturating grids.
		for (phase = 0; phase < 9; phase++) begin
			load_tables(phase % 3);
			for (k = 0; k < 130; k++) begin
				if ($urandom_range(0, 19) == 0)
					send_word(mk(bti_pkg::op_t'($urandom_range(0, 2)), $urandom, $urandom,
						$urandom, $urandom, $urandom));
				else
					send_word(mk(bti_pkg::OP_LOOKUP, $urandom, $urandom, $urandom,
						rand_coord(), rand_coord()));
			end
		end
		s_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// Result side: random stalls, compare each word with the oldest expectation.
	initial begin
		int g;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			g = gap_len();
			if (g > 0) begin
				m_tready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		lookup_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: got %h/%b", $time, m_tdata, m_tuser);
				n_errors++;
			end else begin
				e = pending_results.pop_front();
				if (m_tdata !== e.val || m_tuser[0] !== e.sat) begin
					$display("%0t result mismatch: expected %h/%b got %h/%b",
						$time, e.val, e.sat, m_tdata, m_tuser);
					n_errors++;
				end
			end
		end
	end

	// End of run.
	initial begin
		wait (stim_done);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* bilinear_table_interpolator_core.f */
rtl/bti_pkg.sv
rtl/bti_front.sv
rtl/bti_interp.sv
rtl/bti_back.sv
rtl/bilinear_table_interpolator_core.sv
test/bilinear_table_interpolator_core_tb.sv
